@@ rtl/slbp_pkg.sv @@
// Status LED blink pattern: shared types, codes, register defaults and colour table.
// No dependencies; used by every other file of the block.
package slbp_pkg;

   localparam int DEFAULT_TICK_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH    = 3;
   localparam int CSR_DATA_WIDTH     = 16;
   localparam int PATTERN_WIDTH      = 3;

   typedef enum logic [1:0] {
      MODE_TICK   = 2'd0,
      MODE_SET    = 2'd1,
      MODE_DIRECT = 2'd2,
      MODE_TOGGLE = 2'd3
   } mode_type;

   localparam logic [PATTERN_WIDTH-1:0] PAT_OFF          = 3'd0;
   localparam logic [PATTERN_WIDTH-1:0] PAT_DISCONNECTED = 3'd1;
   localparam logic [PATTERN_WIDTH-1:0] PAT_TENTATIVE    = 3'd2;
   localparam logic [PATTERN_WIDTH-1:0] PAT_CONNECTED    = 3'd3;
   localparam logic [PATTERN_WIDTH-1:0] PAT_BINDING      = 3'd4;
   localparam logic [PATTERN_WIDTH-1:0] PAT_WIFI         = 3'd5;
   localparam logic [PATTERN_WIDTH-1:0] PAT_ERROR        = 3'd6;
   localparam logic [PATTERN_WIDTH-1:0] PAT_BOOT         = 3'd7;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SLOW_HALF   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MEDIUM_HALF = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FAST_HALF   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RAPID_HALF  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ON_TIME     = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAP_TIME    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PAUSE_TIME  = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ACTIVE_LOW  = 3'd7;

   localparam logic [CSR_DATA_WIDTH-1:0] RST_SLOW_HALF   = 16'd500;
   localparam logic [CSR_DATA_WIDTH-1:0] RST_MEDIUM_HALF = 16'd250;
   localparam logic [CSR_DATA_WIDTH-1:0] RST_FAST_HALF   = 16'd50;
   localparam logic [CSR_DATA_WIDTH-1:0] RST_RAPID_HALF  = 16'd75;
   localparam logic [CSR_DATA_WIDTH-1:0] RST_ON_TIME     = 16'd100;
   localparam logic [CSR_DATA_WIDTH-1:0] RST_GAP_TIME    = 16'd100;
   localparam logic [CSR_DATA_WIDTH-1:0] RST_PAUSE_TIME  = 16'd600;
   localparam logic                      RST_ACTIVE_LOW  = 1'b1;

   localparam logic [1:0] PHASE_FLASH_ONE = 2'd0;
   localparam logic [1:0] PHASE_GAP       = 2'd1;
   localparam logic [1:0] PHASE_PAUSE     = 2'd3;

   typedef struct packed {
      logic [CSR_DATA_WIDTH-1:0] slow_half;
      logic [CSR_DATA_WIDTH-1:0] medium_half;
      logic [CSR_DATA_WIDTH-1:0] fast_half;
      logic [CSR_DATA_WIDTH-1:0] rapid_half;
      logic [CSR_DATA_WIDTH-1:0] on_time;
      logic [CSR_DATA_WIDTH-1:0] gap_time;
      logic [CSR_DATA_WIDTH-1:0] pause_time;
      logic                      active_low;
   } cfg_type;

   typedef struct packed {
      mode_type                 mode;
      logic [PATTERN_WIDTH-1:0] pattern;
      logic                     level;
   } cmd_type;

   typedef struct packed {
      logic                     led_on;
      logic                     red_pin;
      logic                     green_pin;
      logic                     blue_pin;
      logic [PATTERN_WIDTH-1:0] active_pattern;
   } result_type;

   // lit colour: bit 2 red, bit 1 green, bit 0 blue
   function automatic logic [2:0] colour_of(input logic [PATTERN_WIDTH-1:0] pat);
      logic [2:0] rgb;
      case (pat)
         PAT_OFF:          rgb = 3'b000;
         PAT_DISCONNECTED: rgb = 3'b010;
         PAT_TENTATIVE:    rgb = 3'b011;
         PAT_CONNECTED:    rgb = 3'b010;
         PAT_BINDING:      rgb = 3'b101;
         PAT_WIFI:         rgb = 3'b001;
         PAT_ERROR:        rgb = 3'b100;
         PAT_BOOT:         rgb = 3'b111;
         default:          rgb = 3'b000;
      endcase
      return rgb;
   endfunction

endpackage

@@ rtl/slbp_req_if.sv @@
// Status LED blink pattern: request and response channel interfaces.
// Depends on slbp_pkg for payload widths.
interface slbp_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        mode;
   logic [slbp_pkg::PATTERN_WIDTH-1:0] pattern;
   logic                              level;

   modport source (output valid, mode, pattern, level, input ready);
   modport sink   (input valid, mode, pattern, level, output ready);
endinterface

interface slbp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              led_on;
   logic                              red_pin;
   logic                              green_pin;
   logic                              blue_pin;
   logic [slbp_pkg::PATTERN_WIDTH-1:0] active_pattern;

   modport source (output valid, led_on, red_pin, green_pin, blue_pin, active_pattern,
                   input ready);
   modport sink   (input valid, led_on, red_pin, green_pin, blue_pin, active_pattern,
                   output ready);
endinterface

@@ rtl/status_led_blink_pattern.sv @@
// Status LED blink pattern: top level with request register and response register.
// Depends on slbp_pkg, slbp_req_if/slbp_rsp_if, slbp_csr and slbp_engine.
//
//   channel | dir | fields                                            | handshake
//   req_ch  | in  | mode[1:0] pattern[2:0] level                      | valid/ready
//   rsp_ch  | out | led_on red_pin green_pin blue_pin active_pattern  | valid/ready
//   csr_*   | in  | csr_index[2:0] csr_wdata[15:0]                    | csr_we
//
// One beat per cycle unless the response stalls; an accepted request beat sits in the
// request register, then the response register (state update and result register).
// Synchronous reset clears pattern state, pipeline valids and registers to defaults.
// A stalled response holds the request register; ready drops only when both are full.
module status_led_blink_pattern #(
   parameter int TICK_WIDTH = slbp_pkg::DEFAULT_TICK_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   slbp_req_if.sink                             req_ch,
   slbp_rsp_if.source                           rsp_ch,
   input  logic                                 csr_we,
   input  logic [slbp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [slbp_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   slbp_pkg::cfg_type    cfg;
   slbp_pkg::cmd_type    cmd_ff;
   slbp_pkg::result_type result;
   slbp_pkg::result_type rsp_ff;
   logic                 req_valid_ff, req_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 advance;
   logic                 req_fire;

   slbp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   slbp_engine #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cmd     (cmd_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !req_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_valid_in = req_fire || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff.mode    <= slbp_pkg::mode_type'(req_ch.mode);
         cmd_ff.pattern <= req_ch.pattern;
         cmd_ff.level   <= req_ch.level;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.led_on         = rsp_ff.led_on;
   assign rsp_ch.red_pin        = rsp_ff.red_pin;
   assign rsp_ch.green_pin      = rsp_ff.green_pin;
   assign rsp_ch.blue_pin       = rsp_ff.blue_pin;
   assign rsp_ch.active_pattern = rsp_ff.active_pattern;

`ifndef ASSERT_OFF
   a_dark_pins_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.led_on
      |-> rsp_ff.red_pin == rsp_ff.green_pin && rsp_ff.green_pin == rsp_ff.blue_pin)
      else $error("unlit response with a coloured pin");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> req_valid_ff)
      else $error("accepted request beat lost");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed beat produced no response");
`endif

endmodule

@@ rtl/slbp_csr.sv @@
// Status LED blink pattern: configuration register file (write only).
// Depends on slbp_pkg for register indexes, reset values and cfg_type.
module slbp_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [slbp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [slbp_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output slbp_pkg::cfg_type                    cfg
);

   slbp_pkg::cfg_type cfg_ff;
   slbp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            slbp_pkg::REG_SLOW_HALF:   cfg_in.slow_half   = csr_wdata;
            slbp_pkg::REG_MEDIUM_HALF: cfg_in.medium_half = csr_wdata;
            slbp_pkg::REG_FAST_HALF:   cfg_in.fast_half   = csr_wdata;
            slbp_pkg::REG_RAPID_HALF:  cfg_in.rapid_half  = csr_wdata;
            slbp_pkg::REG_ON_TIME:     cfg_in.on_time     = csr_wdata;
            slbp_pkg::REG_GAP_TIME:    cfg_in.gap_time    = csr_wdata;
            slbp_pkg::REG_PAUSE_TIME:  cfg_in.pause_time  = csr_wdata;
            slbp_pkg::REG_ACTIVE_LOW:  cfg_in.active_low  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slow_half   <= slbp_pkg::RST_SLOW_HALF;
         cfg_ff.medium_half <= slbp_pkg::RST_MEDIUM_HALF;
         cfg_ff.fast_half   <= slbp_pkg::RST_FAST_HALF;
         cfg_ff.rapid_half  <= slbp_pkg::RST_RAPID_HALF;
         cfg_ff.on_time     <= slbp_pkg::RST_ON_TIME;
         cfg_ff.gap_time    <= slbp_pkg::RST_GAP_TIME;
         cfg_ff.pause_time  <= slbp_pkg::RST_PAUSE_TIME;
         cfg_ff.active_low  <= slbp_pkg::RST_ACTIVE_LOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/slbp_engine.sv @@
// Status LED blink pattern: pattern state, tick counter and result logic.
// Depends on slbp_pkg for cmd_type, cfg_type, result_type and pattern codes.
module slbp_engine #(
   parameter int TICK_WIDTH = slbp_pkg::DEFAULT_TICK_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  slbp_pkg::cmd_type      cmd,
   input  slbp_pkg::cfg_type      cfg,
   output slbp_pkg::result_type   result
);

   localparam int CMP_WIDTH = (TICK_WIDTH > slbp_pkg::CSR_DATA_WIDTH) ?
                              TICK_WIDTH : slbp_pkg::CSR_DATA_WIDTH;

   logic [slbp_pkg::PATTERN_WIDTH-1:0] pattern_ff, pattern_in;
   logic                               lit_ff, lit_in;
   logic [TICK_WIDTH-1:0]              elapsed_ff, elapsed_in;
   logic [1:0]                         phase_ff, phase_in;

   logic [TICK_WIDTH-1:0]              elapsed_inc;
   logic [slbp_pkg::CSR_DATA_WIDTH-1:0] limit;
   logic                               blinking;
   logic                               hit;
   logic [1:0]                         phase_next;
   logic [2:0]                         rgb;

   always_comb begin
      elapsed_inc = (&elapsed_ff) ? elapsed_ff : elapsed_ff + TICK_WIDTH'(1);
      blinking    = 1'b1;
      case (pattern_ff)
         slbp_pkg::PAT_DISCONNECTED: limit = cfg.slow_half;
         slbp_pkg::PAT_TENTATIVE:    limit = cfg.medium_half;
         slbp_pkg::PAT_BINDING:      limit = cfg.fast_half;
         slbp_pkg::PAT_ERROR:        limit = cfg.rapid_half;
         slbp_pkg::PAT_WIFI: begin
            if (phase_ff == slbp_pkg::PHASE_PAUSE) begin
               limit = cfg.pause_time;
            end else if (phase_ff == slbp_pkg::PHASE_GAP) begin
               limit = cfg.gap_time;
            end else begin
               limit = cfg.on_time;
            end
         end
         default: begin
            limit    = cfg.on_time;
            blinking = 1'b0;
         end
      endcase
      hit        = blinking && (CMP_WIDTH'(elapsed_inc) >= CMP_WIDTH'(limit));
      phase_next = phase_ff + 2'd1;
   end

   always_comb begin
      pattern_in = pattern_ff;
      lit_in     = lit_ff;
      elapsed_in = elapsed_ff;
      phase_in   = phase_ff;
      case (cmd.mode)
         slbp_pkg::MODE_TICK: begin
            if (!hit) begin
               elapsed_in = elapsed_inc;
            end else if (pattern_ff == slbp_pkg::PAT_WIFI) begin
               elapsed_in = '0;
               phase_in   = phase_next;
               lit_in     = ~phase_next[0];
            end else begin
               elapsed_in = '0;
               lit_in     = ~lit_ff;
            end
         end
         slbp_pkg::MODE_SET: begin
            if (cmd.pattern != pattern_ff) begin
               pattern_in = cmd.pattern;
               elapsed_in = '0;
               phase_in   = slbp_pkg::PHASE_FLASH_ONE;
               lit_in     = !(cmd.pattern == slbp_pkg::PAT_OFF ||
                              cmd.pattern == slbp_pkg::PAT_BOOT);
            end
         end
         slbp_pkg::MODE_DIRECT: lit_in = cmd.level;
         slbp_pkg::MODE_TOGGLE: lit_in = ~lit_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= slbp_pkg::PAT_OFF;
         lit_ff     <= 1'b0;
         elapsed_ff <= '0;
         phase_ff   <= slbp_pkg::PHASE_FLASH_ONE;
      end else if (advance) begin
         pattern_ff <= pattern_in;
         lit_ff     <= lit_in;
         elapsed_ff <= elapsed_in;
         phase_ff   <= phase_in;
      end
   end

   always_comb begin
      rgb                   = lit_in ? slbp_pkg::colour_of(pattern_in) : 3'b000;
      result.led_on         = lit_in;
      result.red_pin        = rgb[2] ^ cfg.active_low;
      result.green_pin      = rgb[1] ^ cfg.active_low;
      result.blue_pin       = rgb[0] ^ cfg.active_low;
      result.active_pattern = pattern_in;
   end

`ifndef ASSERT_OFF
   a_phase_only_wifi: assert property (@(posedge clock) disable iff (reset)
      phase_ff != slbp_pkg::PHASE_FLASH_ONE |-> pattern_ff == slbp_pkg::PAT_WIFI)
      else $error("wifi phase advanced outside wifi pattern");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pattern_ff) && $stable(elapsed_ff) && $stable(phase_ff)
                   && $stable(lit_ff))
      else $error("pattern state moved without a beat");

   a_change_clears: assert property (@(posedge clock) disable iff (reset)
      advance && cmd.mode == slbp_pkg::MODE_SET && cmd.pattern != pattern_ff
      |=> elapsed_ff == '0 && phase_ff == slbp_pkg::PHASE_FLASH_ONE)
      else $error("pattern change did not clear counter and phase");
`endif

endmodule

@@ tb/tb_status_led_blink_pattern.sv @@
// Testbench for status_led_blink_pattern: directed and random command beats under several
// register settings and idle/stall mixes, each response beat checked against a local LED model.
// Depends on slbp_pkg, slbp_req_if/slbp_rsp_if and the RTL of the block.
module tb_status_led_blink_pattern;
   timeunit 1ns;
   timeprecision 1ps;
   import slbp_pkg::*;

   localparam int         TICK_W          = DEFAULT_TICK_WIDTH;
   localparam int         QUIET_LIMIT     = 1000;
   localparam int         MAX_PRINTED     = 50;
   localparam logic [1:0] PHASE_FLASH_TWO = 2'd2;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   slbp_req_if req_if ();
   slbp_rsp_if rsp_if ();

   status_led_blink_pattern #(.TICK_WIDTH(TICK_W)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5ns clock = ~clock;

   cfg_type                  cfg_model;
   logic [PATTERN_WIDTH-1:0] pat_model;
   logic                     lit_model;
   logic [TICK_W-1:0]        ticks_model;
   logic [1:0]               wifi_phase;
   result_type               led_states_due[$];
   int                       mismatches    = 0;
   int                       quiet_cycles  = 0;
   int                       send_idle_pct = 0;
   int                       stall_pct     = 0;

   function automatic result_type predict_led(input cmd_type c);
      logic [31:0] limit;
      logic        blinks;
      logic [2:0]  rgb;
      result_type  r;
      limit  = '0;
      blinks = 1'b1;
      case (c.mode)
         MODE_TICK: begin
            if (ticks_model != '1) ticks_model = ticks_model + 1'b1;
            case (pat_model)
               PAT_DISCONNECTED: limit = 32'(cfg_model.slow_half);
               PAT_TENTATIVE:    limit = 32'(cfg_model.medium_half);
               PAT_BINDING:      limit = 32'(cfg_model.fast_half);
               PAT_ERROR:        limit = 32'(cfg_model.rapid_half);
               PAT_WIFI: begin
                  blinks = 1'b0;
                  if (wifi_phase == PHASE_PAUSE) limit = 32'(cfg_model.pause_time);
                  else if (wifi_phase == PHASE_GAP) limit = 32'(cfg_model.gap_time);
                  else limit = 32'(cfg_model.on_time);
                  if (32'(ticks_model) >= limit) begin
                     ticks_model = '0;
                     wifi_phase  = wifi_phase + 2'd1;
                     lit_model   = (wifi_phase == PHASE_FLASH_ONE) ||
                                   (wifi_phase == PHASE_FLASH_TWO);
                  end
               end
               default: blinks = 1'b0;
            endcase
            if (blinks && 32'(ticks_model) >= limit) begin
               ticks_model = '0;
               lit_model   = !lit_model;
            end
         end
         MODE_SET: begin
            if (c.pattern != pat_model) begin
               pat_model   = c.pattern;
               ticks_model = '0;
               wifi_phase  = PHASE_FLASH_ONE;
               lit_model   = !(c.pattern == PAT_OFF || c.pattern == PAT_BOOT);
            end
         end
         MODE_DIRECT: lit_model = c.level;
         default:     lit_model = !lit_model;
      endcase
      case (pat_model)
         PAT_DISCONNECTED, PAT_CONNECTED: rgb = 3'b010;
         PAT_TENTATIVE:                   rgb = 3'b011;
         PAT_BINDING:                     rgb = 3'b101;
         PAT_WIFI:                        rgb = 3'b001;
         PAT_ERROR:                       rgb = 3'b100;
         PAT_BOOT:                        rgb = 3'b111;
         default:                         rgb = 3'b000;
      endcase
      if (!lit_model) rgb = 3'b000;
      r.led_on         = lit_model;
      r.red_pin        = rgb[2] ^ cfg_model.active_low;
      r.green_pin      = rgb[1] ^ cfg_model.active_low;
      r.blue_pin       = rgb[0] ^ cfg_model.active_low;
      r.active_pattern = pat_model;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatches < MAX_PRINTED) $display("%0t mismatch: %s", $time, what);
      mismatches++;
   endtask

   // model mirror, response checker and register shadow, all sampled at the clock edge
   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      cmd_type    c;
      if (reset) begin
         cfg_model.slow_half   = RST_SLOW_HALF;
         cfg_model.medium_half = RST_MEDIUM_HALF;
         cfg_model.fast_half   = RST_FAST_HALF;
         cfg_model.rapid_half  = RST_RAPID_HALF;
         cfg_model.on_time     = RST_ON_TIME;
         cfg_model.gap_time    = RST_GAP_TIME;
         cfg_model.pause_time  = RST_PAUSE_TIME;
         cfg_model.active_low  = RST_ACTIVE_LOW;
         pat_model   = PAT_OFF;
         lit_model   = 1'b0;
         ticks_model = '0;
         wifi_phase  = PHASE_FLASH_ONE;
         led_states_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_SLOW_HALF:   cfg_model.slow_half   = csr_wdata;
               REG_MEDIUM_HALF: cfg_model.medium_half = csr_wdata;
               REG_FAST_HALF:   cfg_model.fast_half   = csr_wdata;
               REG_RAPID_HALF:  cfg_model.rapid_half  = csr_wdata;
               REG_ON_TIME:     cfg_model.on_time     = csr_wdata;
               REG_GAP_TIME:    cfg_model.gap_time    = csr_wdata;
               REG_PAUSE_TIME:  cfg_model.pause_time  = csr_wdata;
               REG_ACTIVE_LOW:  cfg_model.active_low  = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.led_on         = rsp_if.led_on;
            got.red_pin        = rsp_if.red_pin;
            got.green_pin      = rsp_if.green_pin;
            got.blue_pin       = rsp_if.blue_pin;
            got.active_pattern = rsp_if.active_pattern;
            if (led_states_due.size() == 0) begin
               report_mismatch("response beat with nothing pending");
            end else begin
               want = led_states_due.pop_front();
               if (got.led_on !== want.led_on)
                  report_mismatch($sformatf("led_on %b, expected %b",
                                            got.led_on, want.led_on));
               if (got.red_pin !== want.red_pin)
                  report_mismatch($sformatf("red_pin %b, expected %b",
                                            got.red_pin, want.red_pin));
               if (got.green_pin !== want.green_pin)
                  report_mismatch($sformatf("green_pin %b, expected %b",
                                            got.green_pin, want.green_pin));
               if (got.blue_pin !== want.blue_pin)
                  report_mismatch($sformatf("blue_pin %b, expected %b",
                                            got.blue_pin, want.blue_pin));
               if (got.active_pattern !== want.active_pattern)
                  report_mismatch($sformatf("active_pattern %0d, expected %0d",
                                            got.active_pattern, want.active_pattern));
            end
         end
         if (req_if.valid && req_if.ready) begin
            c.mode    = mode_type'(req_if.mode);
            c.pattern = req_if.pattern;
            c.level   = req_if.level;
            led_states_due.push_back(predict_led(c));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_status_led_blink_pattern: errors");
         $finish;
      end
   end

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_cmd(input mode_type m, input logic [PATTERN_WIDTH-1:0] p,
                           input logic l);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.mode    <= m;
      req_if.pattern <= p;
      req_if.level   <= l;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (led_states_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_regs(input cfg_type c);
      logic [CSR_DATA_WIDTH-1:0] vals [8];
      logic [14:0]               junk;
      settle();
      junk                 = 15'($urandom_range(32767));
      vals[REG_SLOW_HALF]   = c.slow_half;
      vals[REG_MEDIUM_HALF] = c.medium_half;
      vals[REG_FAST_HALF]   = c.fast_half;
      vals[REG_RAPID_HALF]  = c.rapid_half;
      vals[REG_ON_TIME]     = c.on_time;
      vals[REG_GAP_TIME]    = c.gap_time;
      vals[REG_PAUSE_TIME]  = c.pause_time;
      vals[REG_ACTIVE_LOW]  = {junk, c.active_low};
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_INDEX_WIDTH'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_WIDTH-1:0] pick_span();
      int roll;
      roll = $urandom_range(19);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      if (roll < 5) return 16'd1;
      return 16'($urandom_range(12, 2));
   endfunction

   // reset settings: every pattern, repeats, direct set, toggle, unused fields at extremes
   task automatic test_defaults();
      send_idle_pct = 0;
      stall_pct     = 0;
      send_cmd(MODE_TICK,   PAT_BOOT,         1'b1);
      send_cmd(MODE_TOGGLE, PAT_OFF,          1'b0);
      send_cmd(MODE_SET,    PAT_DISCONNECTED, 1'b1);
      send_cmd(MODE_SET,    PAT_DISCONNECTED, 1'b0);
      send_cmd(MODE_TICK,   PAT_OFF,          1'b0);
      send_cmd(MODE_SET,    PAT_TENTATIVE,    1'b0);
      send_cmd(MODE_DIRECT, PAT_BOOT,         1'b0);
      send_cmd(MODE_DIRECT, PAT_OFF,          1'b1);
      send_cmd(MODE_SET,    PAT_CONNECTED,    1'b0);
      send_cmd(MODE_TICK,   PAT_ERROR,        1'b1);
      send_cmd(MODE_SET,    PAT_BINDING,      1'b1);
      send_cmd(MODE_TOGGLE, PAT_WIFI,         1'b1);
      send_cmd(MODE_SET,    PAT_WIFI,         1'b0);
      send_cmd(MODE_TICK,   PAT_BOOT,         1'b0);
      send_cmd(MODE_SET,    PAT_ERROR,        1'b0);
      send_cmd(MODE_TOGGLE, PAT_TENTATIVE,    1'b0);
      send_cmd(MODE_SET,    PAT_BOOT,         1'b1);
      send_cmd(MODE_TICK,   PAT_OFF,          1'b1);
      send_cmd(MODE_TOGGLE, PAT_OFF,          1'b0);
      send_cmd(MODE_SET,    PAT_BOOT,         1'b0);
      send_cmd(MODE_SET,    PAT_OFF,          1'b1);
      send_cmd(MODE_SET,    PAT_OFF,          1'b0);
      send_cmd(MODE_DIRECT, PAT_WIFI,         1'b1);
   endtask

   // zero spans are met on every tick; active-high pins
   task automatic test_zero_spans();
      logic [PATTERN_WIDTH-1:0] blinkers [5];
      cfg_type                  cfg;
      blinkers[0] = PAT_DISCONNECTED;
      blinkers[1] = PAT_TENTATIVE;
      blinkers[2] = PAT_BINDING;
      blinkers[3] = PAT_ERROR;
      blinkers[4] = PAT_WIFI;
      cfg = '0;
      program_regs(cfg);
      send_idle_pct = 23;
      stall_pct     = 23;
      for (int i = 0; i < 5; i++) begin
         send_cmd(MODE_SET, blinkers[i], 1'b0);
         repeat (3) send_cmd(MODE_TICK, blinkers[i], 1'b1);
         send_cmd(MODE_DIRECT, PAT_OFF, 1'b1);
         repeat (2) send_cmd(MODE_TICK, PAT_BOOT, 1'b0);
      end
   endtask

   // widest span is not met within a short run, so the LED holds; then a static pattern
   task automatic test_widest_span();
      cfg_type cfg;
      cfg.slow_half   = '1;
      cfg.medium_half = 16'd1;
      cfg.fast_half   = 16'd1;
      cfg.rapid_half  = 16'd1;
      cfg.on_time     = 16'd1;
      cfg.gap_time    = 16'd1;
      cfg.pause_time  = 16'd1;
      cfg.active_low  = 1'b1;
      program_regs(cfg);
      send_idle_pct = 0;
      stall_pct     = 0;
      send_cmd(MODE_SET, PAT_DISCONNECTED, 1'b0);
      repeat (40) send_cmd(MODE_TICK, PAT_OFF, 1'b0);
      send_cmd(MODE_SET, PAT_CONNECTED, 1'b0);
      repeat (4) send_cmd(MODE_TICK, PAT_DISCONNECTED, 1'b1);
      send_cmd(MODE_TOGGLE, PAT_OFF, 1'b0);
      send_cmd(MODE_TICK, PAT_OFF, 1'b0);
   endtask

   task automatic test_random();
      cfg_type                  cfg;
      int                       roll;
      mode_type                 m;
      logic [PATTERN_WIDTH-1:0] p;
      logic                     l;
      for (int ph = 0; ph < 6; ph++) begin
         cfg.slow_half   = pick_span();
         cfg.medium_half = pick_span();
         cfg.fast_half   = pick_span();
         cfg.rapid_half  = pick_span();
         cfg.on_time     = pick_span();
         cfg.gap_time    = pick_span();
         cfg.pause_time  = pick_span();
         cfg.active_low  = 1'($urandom_range(1));
         program_regs(cfg);
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 81; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 81; end
            default: begin send_idle_pct = 23; stall_pct = 23; end
         endcase
         for (int n = 0; n < 130; n++) begin
            roll = $urandom_range(99);
            if (roll < 75) m = MODE_TICK;
            else if (roll < 82) m = MODE_SET;
            else if (roll < 91) m = MODE_DIRECT;
            else m = MODE_TOGGLE;
            p = PATTERN_WIDTH'($urandom_range(7));
            l = 1'($urandom_range(1));
            send_cmd(m, p, l);
         end
      end
   endtask

   initial begin
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      req_if.valid   <= 1'b0;
      req_if.mode    <= MODE_TICK;
      req_if.pattern <= PAT_OFF;
      req_if.level   <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_defaults();
      test_zero_spans();
      test_widest_span();
      test_random();
      settle();
      if (mismatches == 0) begin
         $display("tb_status_led_blink_pattern: clean");
      end else begin
         $display("tb_status_led_blink_pattern: errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/slbp_pkg.sv
rtl/slbp_req_if.sv
rtl/slbp_csr.sv
rtl/slbp_engine.sv
rtl/status_led_blink_pattern.sv
tb/tb_status_led_blink_pattern.sv
